// ===== hw/rtl/vsi_pkg.sv =====
package vsi_pkg;

    // Saturation limit of every intermediate value: +-(2^62 - 1)
    localparam logic signed [63:0] WLIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    // Register indexes of the configuration port
    localparam logic REG_CORE = 1'b0;
    localparam logic REG_CUT  = 1'b1;

    // Root bits of a squared length (66-bit radicand)
    localparam int MAG_N   = 33;
    // Divider: entry stage, one stage per quotient bit, result stage
    localparam int DIV_LAT = 64;

    // Schedule inside one evaluation, in register stages from the input
    localparam int T_A   = 3;            // r1/r2/r0 products summed
    localparam int T_M   = T_A + MAG_N;  // |r1|, |r2| ready
    localparam int T_Q   = T_M + 6;      // q = FOURPI*|r1|*|r2|
    localparam int T_SUM = 10;           // core sum ready for its root

    // Radicand width of the core root: sum (62 bits) shifted up by f
    function automatic int sqrt_w(input int f);
        return 62 + f + (f % 2);
    endfunction

    // Stage at which both den operands are present
    function automatic int den_start(input int f);
        int t_rt;
        t_rt = T_SUM + sqrt_w(f) / 2;
        return (t_rt > T_Q) ? t_rt : T_Q;
    endfunction

    function automatic int eval_lat(input int f);
        return den_start(f) + 3 + DIV_LAT;
    endfunction

    // Truncate toward zero by f bits, saturate to +-WLIM
    function automatic logic signed [63:0] wfix(input logic signed [129:0] x, input int f);
        logic         neg;
        logic [129:0] m;
        logic [129:0] s;
        neg = x[129];
        m   = neg ? 130'(130'd0 - x) : 130'(x);
        s   = m >> f;
        if (s > 130'(WLIM)) begin
            s = 130'(WLIM);
        end
        return neg ? (64'd0 - s[63:0]) : s[63:0];
    endfunction

endpackage

// ===== hw/rtl/vsi_dly.sv =====
module vsi_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    generate
        if (N == 0) begin : g_none
            assign o_d = i_d;
        end else begin : g_sr
            logic [W-1:0] r_sr [N];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sr[0] <= i_d;
                    for (int k = 1; k < N; k++) begin
                        r_sr[k] <= r_sr[k-1];
                    end
                end
            end
            assign o_d = r_sr[N-1];
        end
    endgenerate

endmodule

// ===== hw/rtl/vsi_mul.sv =====
// 64x64 signed multiply from four 32x32 partial products, two stages
module vsi_mul (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [63:0]   i_a,
    input  logic signed [63:0]   i_b,
    output logic signed [127:0]  o_p
);

    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    logic         r_neg;
    logic [127:0] n_sum;

    assign ma = i_a[63] ? (64'd0 - i_a) : i_a;
    assign mb = i_b[63] ? (64'd0 - i_b) : i_b;

    assign n_sum = {64'd0, r_p00} + ({64'd0, r_p01} << 32) + ({64'd0, r_p10} << 32)
                 + {r_p11, 64'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 64'(ma[31:0])  * 64'(mb[31:0]);
            r_p01 <= 64'(ma[31:0])  * 64'(mb[63:32]);
            r_p10 <= 64'(ma[63:32]) * 64'(mb[31:0]);
            r_p11 <= 64'(ma[63:32]) * 64'(mb[63:32]);
            r_neg <= i_a[63] ^ i_b[63];
            o_p   <= r_neg ? (128'd0 - n_sum) : n_sum;
        end
    end

endmodule

// ===== hw/rtl/vsi_sqrt.sv =====
// Floor square root, one root bit per stage
module vsi_sqrt #(
    parameter int W = 66
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W-1:0]     i_x,
    output logic [W/2-1:0]   o_root
);

    localparam int N = W / 2;

    logic [N+1:0] s_rem  [N+1];
    logic [N-1:0] s_root [N+1];
    logic [W-1:0] s_x    [N+1];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_x[0]    = i_x;

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [N+3:0] t;
        logic [N+3:0] tr;
        assign t  = {s_rem[k], s_x[k][W-1 -: 2]};
        assign tr = {2'b00, s_root[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (t >= tr) begin
                    s_rem[k+1]  <= (N+2)'(t - tr);
                    s_root[k+1] <= {s_root[k][N-2:0], 1'b1};
                end else begin
                    s_rem[k+1]  <= (N+2)'(t);
                    s_root[k+1] <= {s_root[k][N-2:0], 1'b0};
                end
                s_x[k+1] <= s_x[k] << 2;
            end
        end
    end

    assign o_root = s_root[N];

endmodule

// ===== hw/rtl/vsi_div.sv =====
// Signed 128 / positive 63 bit divide, truncating, saturated to +-WLIM.
// Overflow is found up front, so only 62 quotient bits are developed.
module vsi_div (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [127:0]  i_x,
    input  logic [62:0]          i_d,
    output logic signed [63:0]   o_q
);

    localparam int QB = 62;

    logic [127:0]  mag;
    logic [62:0]   s_rem [QB+1];
    logic [QB-1:0] s_lo  [QB+1];
    logic [QB-1:0] s_q   [QB+1];
    logic [62:0]   s_d   [QB+1];
    logic          s_neg [QB+1];
    logic          s_ovf [QB+1];

    assign mag = i_x[127] ? (128'd0 - i_x) : i_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            s_rem[0] <= mag[124:62];
            s_lo[0]  <= mag[61:0];
            s_q[0]   <= '0;
            s_d[0]   <= i_d;
            s_neg[0] <= i_x[127];
            s_ovf[0] <= mag[127:62] >= {3'b000, i_d};
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_st
        logic [63:0] t;
        logic        ge;
        assign t  = {s_rem[k], s_lo[k][QB-1]};
        assign ge = t >= {1'b0, s_d[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                s_rem[k+1] <= ge ? 63'(t - {1'b0, s_d[k]}) : 63'(t);
                s_q[k+1]   <= {s_q[k][QB-2:0], ge};
                s_lo[k+1]  <= s_lo[k] << 1;
                s_d[k+1]   <= s_d[k];
                s_neg[k+1] <= s_neg[k];
                s_ovf[k+1] <= s_ovf[k];
            end
        end
    end

    logic [63:0] qm;
    assign qm = s_ovf[QB] ? vsi_pkg::WLIM : {2'b00, s_q[QB]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= s_neg[QB] ? (64'd0 - qm) : qm;
        end
    end

endmodule

// ===== hw/rtl/vsi_eval.sv =====
// One Biot-Savart kernel evaluation, fully pipelined
module vsi_eval #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [30:0]         i_core,
    input  logic [30:0]         i_cut,
    input  logic signed [32:0]  i_p [3],
    input  logic signed [31:0]  i_a [3],
    input  logic signed [31:0]  i_b [3],
    output logic signed [63:0]  o_v [3],
    output logic                o_zero
);

    localparam int SW    = vsi_pkg::sqrt_w(FRAC_BITS);
    localparam int NS    = SW / 2;
    localparam int T_RT  = vsi_pkg::T_SUM + NS;
    localparam int T_DS  = vsi_pkg::den_start(FRAC_BITS);
    localparam int T_DEN = T_DS + 3;
    localparam int T_M   = vsi_pkg::T_M;
    localparam int T_A   = vsi_pkg::T_A;
    localparam logic [63:0] FOURPI =
        (64'd53972150818 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    // stage 1: difference vectors
    logic signed [33:0] r_r1 [3];
    logic signed [33:0] r_r2 [3];
    logic signed [33:0] r_r0 [3];
    // stage 2: raw products
    logic signed [67:0] r_pc [6];
    logic signed [67:0] r_q1 [3];
    logic signed [67:0] r_q2 [3];
    logic signed [67:0] r_e1 [3];
    logic signed [67:0] r_e2 [3];
    logic signed [67:0] r_e0 [3];
    // stage 3
    logic signed [63:0] r_c [3];
    logic signed [63:0] r_d1;
    logic signed [63:0] r_d2;
    logic signed [63:0] r_r0sq;
    logic [65:0]        r_s1;
    logic [65:0]        r_s2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_r1[i] <= 34'(i_p[i]) - 34'(i_a[i]);
                r_r2[i] <= 34'(i_p[i]) - 34'(i_b[i]);
                r_r0[i] <= 34'(i_b[i]) - 34'(i_a[i]);
                r_q1[i] <= r_r1[i] * r_r1[i];
                r_q2[i] <= r_r2[i] * r_r2[i];
                r_e1[i] <= r_r0[i] * r_r1[i];
                r_e2[i] <= r_r0[i] * r_r2[i];
                r_e0[i] <= r_r0[i] * r_r0[i];
            end
            r_pc[0] <= r_r1[1] * r_r2[2];
            r_pc[1] <= r_r1[2] * r_r2[1];
            r_pc[2] <= r_r1[2] * r_r2[0];
            r_pc[3] <= r_r1[0] * r_r2[2];
            r_pc[4] <= r_r1[0] * r_r2[1];
            r_pc[5] <= r_r1[1] * r_r2[0];
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= vsi_pkg::wfix(130'(r_pc[2*i]) - 130'(r_pc[2*i+1]), FRAC_BITS);
            end
            r_s1   <= 66'(70'(r_q1[0]) + 70'(r_q1[1]) + 70'(r_q1[2]));
            r_s2   <= 66'(70'(r_q2[0]) + 70'(r_q2[1]) + 70'(r_q2[2]));
            r_d1   <= vsi_pkg::wfix(130'(r_e1[0]) + 130'(r_e1[1]) + 130'(r_e1[2]), FRAC_BITS);
            r_d2   <= vsi_pkg::wfix(130'(r_e2[0]) + 130'(r_e2[1]) + 130'(r_e2[2]), FRAC_BITS);
            r_r0sq <= vsi_pkg::wfix(130'(r_e0[0]) + 130'(r_e0[1]) + 130'(r_e0[2]), FRAC_BITS);
        end
    end

    // |c|^2 and its square; |r0|^4 times core
    logic signed [127:0] w_cc [3];
    logic signed [127:0] w_c4p;
    logic signed [127:0] w_r4p;
    logic signed [127:0] w_crp;
    logic signed [63:0]  r_cr2;
    logic signed [63:0]  r_c4;
    logic signed [63:0]  r_r04;
    logic signed [63:0]  r_cr;
    logic [61:0]         r_sum;
    logic                r_cs;
    logic signed [64:0]  n_sum;

    for (genvar i = 0; i < 3; i++) begin : g_cc
        vsi_mul u_mul (.i_clk, .i_en, .i_a(r_c[i]), .i_b(r_c[i]), .o_p(w_cc[i]));
    end
    vsi_mul u_c4  (.i_clk, .i_en, .i_a(r_cr2), .i_b(r_cr2), .o_p(w_c4p));
    vsi_mul u_r4  (.i_clk, .i_en, .i_a(r_r0sq), .i_b(r_r0sq), .o_p(w_r4p));
    vsi_mul u_cr  (.i_clk, .i_en, .i_a(64'(i_core)), .i_b(r_r04), .o_p(w_crp));

    assign n_sum = 65'(r_cr) + 65'(r_c4);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cr2 <= vsi_pkg::wfix(130'(w_cc[0]) + 130'(w_cc[1]) + 130'(w_cc[2]), FRAC_BITS);
            r_cs  <= r_cr2 < 64'(i_cut);
            r_c4  <= vsi_pkg::wfix(130'(w_c4p), FRAC_BITS);
            r_r04 <= vsi_pkg::wfix(130'(w_r4p), FRAC_BITS);
            r_cr  <= vsi_pkg::wfix(130'(w_crp), FRAC_BITS);
            r_sum <= (n_sum > 65'(vsi_pkg::WLIM)) ? vsi_pkg::WLIM[61:0] : n_sum[61:0];
        end
    end

    // square roots
    logic [32:0]   w_m1;
    logic [32:0]   w_m2;
    logic [NS-1:0] w_root;

    vsi_sqrt #(.W(66)) u_sq1 (.i_clk, .i_en, .i_x(r_s1), .o_root(w_m1));
    vsi_sqrt #(.W(66)) u_sq2 (.i_clk, .i_en, .i_x(r_s2), .o_root(w_m2));
    vsi_sqrt #(.W(SW)) u_sqc (.i_clk, .i_en, .i_x(SW'(r_sum) << FRAC_BITS), .o_root(w_root));

    // numerator and q
    logic signed [63:0]  w_d1;
    logic signed [63:0]  w_d2;
    logic signed [127:0] w_n1;
    logic signed [127:0] w_n2;
    logic signed [127:0] w_mmp;
    logic signed [127:0] w_qp;
    logic signed [63:0]  r_num;
    logic signed [63:0]  r_mm;
    logic signed [63:0]  r_q;
    logic                r_nm;
    logic                r_near;
    logic                w_cs;

    vsi_dly #(.W(64), .N(T_M - T_A)) u_dd1 (.i_clk, .i_en, .i_d(r_d1), .o_d(w_d1));
    vsi_dly #(.W(64), .N(T_M - T_A)) u_dd2 (.i_clk, .i_en, .i_d(r_d2), .o_d(w_d2));
    vsi_dly #(.W(1), .N(T_M + 1 - 7)) u_dcs (.i_clk, .i_en, .i_d(r_cs), .o_d(w_cs));

    vsi_mul u_n1 (.i_clk, .i_en, .i_a(w_d1), .i_b(64'(w_m2)), .o_p(w_n1));
    vsi_mul u_n2 (.i_clk, .i_en, .i_a(w_d2), .i_b(64'(w_m1)), .o_p(w_n2));
    vsi_mul u_mm (.i_clk, .i_en, .i_a(64'(w_m1)), .i_b(64'(w_m2)), .o_p(w_mmp));
    vsi_mul u_fp (.i_clk, .i_en, .i_a(FOURPI), .i_b(r_mm), .o_p(w_qp));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nm   <= (w_m1 < 33'(i_cut)) || (w_m2 < 33'(i_cut));
            r_near <= r_nm || w_cs;
            r_num  <= vsi_pkg::wfix(130'(w_n1) - 130'(w_n2), FRAC_BITS);
            r_mm   <= vsi_pkg::wfix(130'(w_mmp), FRAC_BITS);
            r_q    <= vsi_pkg::wfix(130'(w_qp), FRAC_BITS);
        end
    end

    // denominator
    logic signed [63:0]  w_qd;
    logic signed [63:0]  w_c2d;
    logic [NS-1:0]       w_rtd;
    logic signed [127:0] w_denp;
    logic signed [63:0]  r_den;
    logic                w_neard;

    vsi_dly #(.W(64), .N(T_DS - vsi_pkg::T_Q)) u_dq (.i_clk, .i_en, .i_d(r_q), .o_d(w_qd));
    vsi_dly #(.W(64), .N(T_DS - 6)) u_dc2 (.i_clk, .i_en, .i_d(r_cr2), .o_d(w_c2d));
    vsi_dly #(.W(NS), .N(T_DS - T_RT)) u_drt (.i_clk, .i_en, .i_d(w_root), .o_d(w_rtd));
    vsi_dly #(.W(1), .N(T_DEN - T_M - 2)) u_dnr (.i_clk, .i_en, .i_d(r_near), .o_d(w_neard));

    vsi_mul u_den (
        .i_clk, .i_en,
        .i_a (w_qd),
        .i_b ((i_core != '0) ? 64'(w_rtd) : w_c2d),
        .o_p (w_denp)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= vsi_pkg::wfix(130'(w_denp), FRAC_BITS);
        end
    end

    // per-component c_i*num / den
    logic w_zero;
    logic w_zerod;

    assign w_zero = w_neard || (r_den <= 64'sd0);

    vsi_dly #(.W(1), .N(vsi_pkg::DIV_LAT)) u_dz (.i_clk, .i_en, .i_d(w_zero), .o_d(w_zerod));

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic signed [63:0]  w_cd;
        logic signed [127:0] w_xp;
        logic signed [127:0] w_xd;
        logic signed [63:0]  w_q;
        vsi_dly #(.W(64), .N(T_M + 3 - T_A)) u_dc (.i_clk, .i_en, .i_d(r_c[i]), .o_d(w_cd));
        vsi_mul u_x (.i_clk, .i_en, .i_a(w_cd), .i_b(r_num), .o_p(w_xp));
        vsi_dly #(.W(128), .N(T_DEN - T_M - 5)) u_dx (.i_clk, .i_en, .i_d(w_xp), .o_d(w_xd));
        vsi_div u_div (.i_clk, .i_en, .i_x(w_xd), .i_d(r_den[62:0]), .o_q(w_q));
        assign o_v[i] = w_zerod ? 64'sd0 : w_q;
    end

    assign o_zero = w_zerod;

endmodule

// ===== hw/rtl/vortex_segment_influence.sv =====
// Induced velocity of a straight vortex segment of unit circulation at a field
// point, with the wing mirror image folded in.
// Input channel (s_*): one word per point/segment pair, nine signed Q16.16
// coordinates. Output channel (m_*): one word per input word, in order:
// saturated velocity sums plus the two zeroed flags.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 = core radius^4, 1 = singular cutoff); write only while the block is empty.
// Throughput: one word per cycle while the output is not stalled. The pipeline
// depth is set by the core-radius square root (one root bit per stage) and
// the divider, both fully pipelined.
// Both evaluations (direct and mirrored) run side by side in their own lanes.
// Stall: the whole pipeline advances only when the output register is empty or
// being taken, so o_s_tready drops exactly while a result waits unread; no
// word is lost or repeated.
// Reset: valid bits clear, core radius^4 returns to 0 (singular kernel) and
// the cutoff to 1.
module vortex_segment_influence #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [287:0]  i_s_tdata,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // vel_x, vel_y, vel_z
    output logic [95:0]   o_m_tdata,
    // direct_zeroed, mirror_zeroed
    output logic [1:0]    o_m_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [30:0]   i_cfg_data
);

    localparam int ELAT = vsi_pkg::eval_lat(FRAC_BITS);
    localparam int LAT  = ELAT + 1;

    logic [30:0]    r_core;
    logic [30:0]    r_cut;
    logic [LAT-1:0] r_vld;
    logic           en;

    // Pipeline moves whenever the output slot is free or drained this cycle
    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= '0;
            r_cut  <= 31'd1;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vsi_pkg::REG_CORE: r_core <= i_cfg_data;
                    vsi_pkg::REG_CUT:  r_cut  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
            end
        end
    end

    // unpack; mirror negates point y, which needs one extra bit
    logic signed [32:0] pd [3];
    logic signed [32:0] pm [3];
    logic signed [31:0] sa [3];
    logic signed [31:0] sb [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pd[i] = 33'($signed(i_s_tdata[32*i +: 32]));
            sa[i] = $signed(i_s_tdata[96 + 32*i +: 32]);
            sb[i] = $signed(i_s_tdata[192 + 32*i +: 32]);
            pm[i] = pd[i];
        end
        pm[1] = 33'sd0 - pd[1];
    end

    logic signed [63:0] vd [3];
    logic signed [63:0] vm [3];
    logic               zd;
    logic               zm;

    vsi_eval #(.FRAC_BITS(FRAC_BITS)) u_direct (
        .i_clk, .i_en(en), .i_core(r_core), .i_cut(r_cut),
        .i_p(pd), .i_a(sa), .i_b(sb), .o_v(vd), .o_zero(zd)
    );

    vsi_eval #(.FRAC_BITS(FRAC_BITS)) u_mirror (
        .i_clk, .i_en(en), .i_core(r_core), .i_cut(r_cut),
        .i_p(pm), .i_a(sa), .i_b(sb), .o_v(vm), .o_zero(zm)
    );

    // x and z add the image, y subtracts it; saturate to 32 bits
    function automatic logic [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -65'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_m_tdata[31:0]  <= sat32(65'(vd[0]) + 65'(vm[0]));
            o_m_tdata[63:32] <= sat32(65'(vd[1]) - 65'(vm[1]));
            o_m_tdata[95:64] <= sat32(65'(vd[2]) + 65'(vm[2]));
            o_m_tuser        <= {zm, zd};
        end
    end

endmodule
